// File: sv/ped_pkg.sv
// Shared types, constants and the microcode program of the polynomial derivative evaluator.
package ped_pkg;

    // Store geometry: up to eight coefficients, so degree seven at most.
    localparam int CAPACITY = 8;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;
    localparam logic [CNT_W-1:0] CAP_COUNT = 4'd8;
    localparam logic [IDX_W-1:0] LAST_IDX  = 3'd7;

    // Factorial scaling starts with the factor two.
    localparam logic [IDX_W-1:0] FACT_FIRST = 3'd2;

    // Arithmetic widths of the shared multiply-accumulate unit.
    localparam int VAL_W  = 48;
    localparam int OPD_W  = 32;
    localparam int HALF_W = 24;
    localparam int PROD_W = HALF_W + OPD_W;
    localparam int FULL_W = VAL_W + OPD_W;
    localparam int MAG_W  = VAL_W + 1;
    localparam int SUM_W  = VAL_W + 2;
    localparam int FRAC_W = 16;

    localparam logic [FULL_W-1:0] ROUND_HALF = 80'd32768;
    localparam logic [MAG_W-1:0]  MAG_LIMIT  = 49'h1_0000_0000_0000;
    localparam logic signed [VAL_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] MIN48 = 48'sh8000_0000_0000;

    // Payload of one input transaction.
    typedef struct packed {
        logic signed [31:0] coef;
        logic signed [31:0] x_point;
        logic               last_coef;
    } coef_item_t;

    // Payload of one output transaction.
    typedef struct packed {
        logic signed [47:0] deriv_value;
        logic [5:0]         deriv_order;
        logic               last_result;
        logic               overflow_flag;
    } result_item_t;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        ACT_IDLE,
        ACT_INIT,
        ACT_MUL_LO,
        ACT_MUL_HI,
        ACT_SUM,
        ACT_ACC_H,
        ACT_FSET,
        ACT_ACC_F,
        ACT_OSET,
        ACT_OUT,
        ACT_NOP
    } act_e;

    // Second multiplier operand: the evaluation point or the factorial factor.
    typedef enum logic {
        XSEL_POINT,
        XSEL_FACTOR
    } xsel_e;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_WAIT,
        COND_N_ZERO,
        COND_N_LT2,
        COND_H_MORE,
        COND_F_MORE,
        COND_O_MORE
    } cond_e;

    localparam int UPC_W = 4;

    // One control word.
    typedef struct packed {
        act_e              act;
        xsel_e             xsel;
        cond_e             cond;
        logic [UPC_W-1:0]  target;
    } uword_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic n_zero;
        logic n_lt2;
        logic h_more;
        logic f_more;
        logic o_more;
    } status_t;

    // Microcode addresses.
    localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] UA_INIT = 4'd1;
    localparam logic [UPC_W-1:0] UA_HLO  = 4'd2;
    localparam logic [UPC_W-1:0] UA_HHI  = 4'd3;
    localparam logic [UPC_W-1:0] UA_HSUM = 4'd4;
    localparam logic [UPC_W-1:0] UA_HACC = 4'd5;
    localparam logic [UPC_W-1:0] UA_FSET = 4'd6;
    localparam logic [UPC_W-1:0] UA_FLO  = 4'd7;
    localparam logic [UPC_W-1:0] UA_FHI  = 4'd8;
    localparam logic [UPC_W-1:0] UA_FSUM = 4'd9;
    localparam logic [UPC_W-1:0] UA_FACC = 4'd10;
    localparam logic [UPC_W-1:0] UA_OSET = 4'd11;
    localparam logic [UPC_W-1:0] UA_OUT  = 4'd12;
    localparam logic [UPC_W-1:0] UA_DONE = 4'd13;

    // The microcode program: Horner passes, factorial scaling, then result output.
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            UA_IDLE: w = '{act: ACT_IDLE,   xsel: XSEL_POINT,  cond: COND_WAIT,   target: UA_IDLE};
            UA_INIT: w = '{act: ACT_INIT,   xsel: XSEL_POINT,  cond: COND_N_ZERO, target: UA_FSET};
            UA_HLO:  w = '{act: ACT_MUL_LO, xsel: XSEL_POINT,  cond: COND_NEXT,   target: UA_IDLE};
            UA_HHI:  w = '{act: ACT_MUL_HI, xsel: XSEL_POINT,  cond: COND_NEXT,   target: UA_IDLE};
            UA_HSUM: w = '{act: ACT_SUM,    xsel: XSEL_POINT,  cond: COND_NEXT,   target: UA_IDLE};
            UA_HACC: w = '{act: ACT_ACC_H,  xsel: XSEL_POINT,  cond: COND_H_MORE, target: UA_HLO};
            UA_FSET: w = '{act: ACT_FSET,   xsel: XSEL_FACTOR, cond: COND_N_LT2,  target: UA_OSET};
            UA_FLO:  w = '{act: ACT_MUL_LO, xsel: XSEL_FACTOR, cond: COND_NEXT,   target: UA_IDLE};
            UA_FHI:  w = '{act: ACT_MUL_HI, xsel: XSEL_FACTOR, cond: COND_NEXT,   target: UA_IDLE};
            UA_FSUM: w = '{act: ACT_SUM,    xsel: XSEL_FACTOR, cond: COND_NEXT,   target: UA_IDLE};
            UA_FACC: w = '{act: ACT_ACC_F,  xsel: XSEL_FACTOR, cond: COND_F_MORE, target: UA_FLO};
            UA_OSET: w = '{act: ACT_OSET,   xsel: XSEL_POINT,  cond: COND_NEXT,   target: UA_IDLE};
            UA_OUT:  w = '{act: ACT_OUT,    xsel: XSEL_POINT,  cond: COND_O_MORE, target: UA_OUT};
            UA_DONE: w = '{act: ACT_NOP,    xsel: XSEL_POINT,  cond: COND_ALWAYS, target: UA_IDLE};
            default: w = '{act: ACT_NOP,    xsel: XSEL_POINT,  cond: COND_ALWAYS, target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: sv/ped_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module ped_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  ped_pkg::status_t status,
    output ped_pkg::uword_t  uw
);
    import ped_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             jump;

    // Fetch the control word of the current step.
    assign uw = ucode(upc_reg);

    // Evaluate the jump condition of the current step.
    always_comb
    begin
        case (uw.cond)
            COND_NEXT:   jump = 1'b0;
            COND_ALWAYS: jump = 1'b1;
            COND_WAIT:   jump = !status.start;
            COND_N_ZERO: jump = status.n_zero;
            COND_N_LT2:  jump = status.n_lt2;
            COND_H_MORE: jump = status.h_more;
            COND_F_MORE: jump = status.f_more;
            COND_O_MORE: jump = status.o_more;
            default:     jump = 1'b1;
        endcase
    end

    // Next step address.
    always_comb
    begin
        if (jump)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: sv/ped_mac.sv
// Shared multiply, round and saturate unit for the Horner and factorial steps.
module ped_mac (
    input  logic                clk,
    input  ped_pkg::act_e       act,
    input  logic signed [47:0]  w_val,
    input  logic [31:0]         x_mag,
    input  logic                x_neg,
    input  logic signed [47:0]  addend,
    output logic signed [47:0]  result,
    output logic                sat
);
    import ped_pkg::*;

    logic              w_neg;
    logic [VAL_W-1:0]  w_mag;
    logic [HALF_W-1:0] mul_a;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_lo_reg;
    logic [PROD_W-1:0] prod_hi_reg;
    logic [FULL_W-1:0] full;
    logic [63:0]       mag_raw;
    logic              mag_big;
    logic [MAG_W-1:0]  mag_reg;
    logic signed [SUM_W-1:0] p_pos;
    logic signed [SUM_W-1:0] p_sgn;
    logic signed [SUM_W-1:0] sum;

    // Magnitude of the accumulator operand.
    assign w_neg = w_val[VAL_W-1];
    assign w_mag = w_neg ? $unsigned(-w_val) : $unsigned(w_val);

    // One 24 by 32 multiplier, used for the low half and then the high half.
    assign mul_a = (act == ACT_MUL_HI) ? w_mag[VAL_W-1:HALF_W] : w_mag[HALF_W-1:0];
    assign prod  = {{(PROD_W-HALF_W){1'b0}}, mul_a} * {{(PROD_W-OPD_W){1'b0}}, x_mag};

    // Join the halves, round to nearest and clamp the magnitude at 2^48.
    assign full    = {prod_hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, prod_lo_reg} + ROUND_HALF;
    assign mag_raw = full[FULL_W-1:FRAC_W];
    assign mag_big = (|mag_raw[63:MAG_W]) || (mag_raw[MAG_W-1] && (|mag_raw[VAL_W-1:0]));

    always_ff @(posedge clk)
    begin
        if (act == ACT_MUL_LO)
        begin
            prod_lo_reg <= prod;
        end
        if (act == ACT_MUL_HI)
        begin
            prod_hi_reg <= prod;
        end
        if (act == ACT_SUM)
        begin
            mag_reg <= mag_big ? MAG_LIMIT : mag_raw[MAG_W-1:0];
        end
    end

    // Apply the sign, add the addend and saturate to 48 bits.
    assign p_pos = $signed({1'b0, mag_reg});
    assign p_sgn = (w_neg ^ x_neg) ? -p_pos : p_pos;
    assign sum   = p_sgn + {{(SUM_W-VAL_W){addend[VAL_W-1]}}, addend};
    assign sat   = (sum[SUM_W-1:VAL_W-1] != 3'b000) && (sum[SUM_W-1:VAL_W-1] != 3'b111);

    always_comb
    begin
        if (!sat)
        begin
            result = sum[VAL_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            result = MIN48;
        end
        else
        begin
            result = MAX48;
        end
    end

endmodule

// File: sv/ped_datapath.sv
// Coefficient and accumulator stores, loop counters and the output register.
module ped_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ped_pkg::uword_t       uw,
    output ped_pkg::status_t      status,
    input  logic                  coef_valid,
    output logic                  coef_ready,
    input  ped_pkg::coef_item_t   coef_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ped_pkg::result_item_t result_item
);
    import ped_pkg::*;

    logic [CNT_W-1:0]        coef_count_reg;
    logic [CNT_W-1:0]        coef_count_next;
    logic                    overflow_seen_reg;
    logic                    overflow_seen_next;
    logic [IDX_W-1:0]        n_reg;
    logic [IDX_W-1:0]        n_next;
    logic [IDX_W-1:0]        i_reg;
    logic [IDX_W-1:0]        i_next;
    logic [IDX_W-1:0]        j_reg;
    logic [IDX_W-1:0]        j_next;
    logic [IDX_W-1:0]        f_reg;
    logic [IDX_W-1:0]        f_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_item_t            out_reg;

    logic signed [31:0]      coef_store [CAPACITY];
    logic signed [VAL_W-1:0] work_store [CAPACITY];
    logic signed [31:0]      x_reg;
    logic signed [VAL_W-1:0] prev_reg;

    logic                    accept;
    logic                    full;
    logic                    start;
    logic                    out_free;
    logic signed [VAL_W-1:0] w_cur;
    logic signed [VAL_W-1:0] coef_ext;
    logic signed [VAL_W-1:0] addend;
    logic [OPD_W-1:0]        x_mag;
    logic                    x_neg;
    logic signed [VAL_W-1:0] mac_res;
    logic                    mac_sat;

    // Input and output handshakes.
    assign coef_ready   = (uw.act == ACT_IDLE);
    assign accept       = coef_valid && coef_ready;
    assign full         = (coef_count_reg == CAP_COUNT);
    assign start        = accept && coef_item.last_coef;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    // Operand selection for the shared multiply-accumulate unit.
    assign w_cur    = work_store[j_reg];
    assign coef_ext = {{(VAL_W-32){coef_store[i_reg][31]}}, coef_store[i_reg]};

    always_comb
    begin
        if (uw.xsel == XSEL_FACTOR)
        begin
            x_neg = 1'b0;
            x_mag = {{(OPD_W-IDX_W-FRAC_W){1'b0}}, f_reg, {FRAC_W{1'b0}}};
        end
        else
        begin
            x_neg = x_reg[31];
            x_mag = x_reg[31] ? $unsigned(-x_reg) : $unsigned(x_reg);
        end
    end

    always_comb
    begin
        if (uw.act == ACT_ACC_F)
        begin
            addend = '0;
        end
        else if (j_reg == '0)
        begin
            addend = coef_ext;
        end
        else
        begin
            addend = prev_reg;
        end
    end

    ped_mac u_mac (
        .clk    (clk),
        .act    (uw.act),
        .w_val  (w_cur),
        .x_mag  (x_mag),
        .x_neg  (x_neg),
        .addend (addend),
        .result (mac_res),
        .sat    (mac_sat)
    );

    // Status flags for the sequencer's jumps.
    assign status.start  = start;
    assign status.n_zero = (n_reg == '0);
    assign status.n_lt2  = (n_reg < FACT_FIRST);
    assign status.h_more = !((j_reg == i_reg) && (i_reg == '0));
    assign status.f_more = !((f_reg == j_reg) && (j_reg == n_reg));
    assign status.o_more = !out_free || (j_reg != n_reg);

    // Counter and flag updates per microcode action.
    always_comb
    begin
        coef_count_next    = coef_count_reg;
        overflow_seen_next = overflow_seen_reg;
        n_next             = n_reg;
        i_next             = i_reg;
        j_next             = j_reg;
        f_next             = f_reg;
        ovf_next           = ovf_reg;
        case (uw.act)
            ACT_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        coef_count_next = coef_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_seen_next = 1'b1;
                    end
                    if (coef_item.last_coef)
                    begin
                        coef_count_next    = '0;
                        overflow_seen_next = 1'b0;
                        n_next             = full ? LAST_IDX : coef_count_reg[IDX_W-1:0];
                        i_next             = full ? LAST_IDX : coef_count_reg[IDX_W-1:0];
                        ovf_next           = overflow_seen_reg || full;
                    end
                end
            end
            ACT_INIT:
            begin
                i_next = i_reg - 1'b1;
                j_next = '0;
            end
            ACT_ACC_H:
            begin
                ovf_next = ovf_reg || mac_sat;
                if (j_reg == i_reg)
                begin
                    i_next = i_reg - 1'b1;
                    j_next = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ACT_FSET:
            begin
                j_next = FACT_FIRST;
                f_next = FACT_FIRST;
            end
            ACT_ACC_F:
            begin
                ovf_next = ovf_reg || mac_sat;
                if (f_reg == j_reg)
                begin
                    j_next = j_reg + 1'b1;
                    f_next = FACT_FIRST;
                end
                else
                begin
                    f_next = f_reg + 1'b1;
                end
            end
            ACT_OSET:
            begin
                j_next = '0;
            end
            ACT_OUT:
            begin
                if (out_free)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if ((uw.act == ACT_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            n_reg             <= '0;
            i_reg             <= '0;
            j_reg             <= '0;
            f_reg             <= '0;
            ovf_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            coef_count_reg    <= coef_count_next;
            overflow_seen_reg <= overflow_seen_next;
            n_reg             <= n_next;
            i_reg             <= i_next;
            j_reg             <= j_next;
            f_reg             <= f_next;
            ovf_reg           <= ovf_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Coefficient store, accumulators and output payload.
    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            coef_store[coef_count_reg[IDX_W-1:0]] <= coef_item.coef;
        end
        if (start)
        begin
            x_reg <= coef_item.x_point;
        end
        if (uw.act == ACT_INIT)
        begin
            for (int k = 0; k < CAPACITY; k++)
            begin
                work_store[k] <= coef_ext;
            end
        end
        if ((uw.act == ACT_ACC_H) || (uw.act == ACT_ACC_F))
        begin
            work_store[j_reg] <= mac_res;
        end
        if (uw.act == ACT_ACC_H)
        begin
            prev_reg <= mac_res;
        end
        if ((uw.act == ACT_OUT) && out_free)
        begin
            out_reg.deriv_value   <= w_cur;
            out_reg.deriv_order   <= {{(6-IDX_W){1'b0}}, j_reg};
            out_reg.last_result   <= (j_reg == n_reg);
            out_reg.overflow_flag <= ovf_reg;
        end
    end

endmodule

// File: sv/poly_eval_all_derivatives.sv
// Polynomial evaluator that returns the value and every derivative at one point.
//
// Coefficients arrive lowest order first, one per transaction, signed Q16.16; the
// transaction marked last also carries the evaluation point and starts the work.
// Up to eight coefficients are kept; further ones are dropped and raise the overflow
// flag on the next evaluation. For a polynomial of degree n the block returns n+1
// results, order 0 upward, each the k-th derivative in signed Q32.16 that saturates
// and raises the flag. Coefficients are accepted one per cycle while idle. After the last
// coefficient the block accepts no more until it has issued all its results: each of the
// n*n multiply-accumulate steps (Horner passes plus factorial scaling) runs through one
// shared 24 by 32 multiplier as low product, high product, sum and accumulate, stepped by
// a microcode sequencer, and results leave at one per cycle while result_ready is high.
module poly_eval_all_derivatives (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  coef_valid,
    output logic                  coef_ready,
    input  ped_pkg::coef_item_t   coef_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ped_pkg::result_item_t result_item
);
    import ped_pkg::*;

    uword_t  uw;
    status_t status;

    // Control: step counter and microcode store.
    ped_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uw     (uw)
    );

    // Data: stores, counters, arithmetic and output register.
    ped_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .uw           (uw),
        .status       (status),
        .coef_valid   (coef_valid),
        .coef_ready   (coef_ready),
        .coef_item    (coef_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

// File: test/poly_eval_all_derivatives_tb.sv
// Self-checking testbench for the polynomial evaluator that returns all derivatives.
`timescale 1ns / 100ps

module poly_eval_all_derivatives_tb;

    import ped_pkg::*;

    localparam longint SAT_HI       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO       = -64'sh0000_8000_0000_0000;
    localparam logic [63:0] MAG_CAP = 64'h0001_0000_0000_0000;
    localparam int QUIET_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int STALL_HOLD       = 400;
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic         clk;
    logic         rst_n;
    logic         coef_valid;
    logic         coef_ready;
    coef_item_t   coef_item;
    logic         result_valid;
    logic         result_ready;
    result_item_t result_item;

    // Predictor state: stored coefficients, their count and the dropped flag.
    longint       pred_coefs [CAPACITY];
    int           pred_count;
    bit           pred_dropped;
    result_item_t deriv_expected_q[$];

    int fail_count;
    int items_sent;
    int evals_sent;
    int results_checked;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_request;
    int hold_left = 0;
    int quiet_cycles;

    poly_eval_all_derivatives u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef_valid   (coef_valid),
        .coef_ready   (coef_ready),
        .coef_item    (coef_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // Clamp to the signed 48-bit range and note the saturation.
    function automatic longint clamp48(input longint v, inout bit ov);
        if (v > SAT_HI) begin
            ov = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            ov = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // One Horner step: round(w * x / 2^16) to nearest, ties away from zero, plus addend.
    function automatic longint horner_mac(input longint w, input longint x,
                                          input longint addend, inout bit ov);
        bit         neg;
        bit [63:0]  wm;
        bit [63:0]  xm;
        bit [63:0]  hi;
        bit [63:0]  lo;
        bit [63:0]  m;
        longint     p;
        neg = (w < 0) != (x < 0);
        wm  = (w < 0) ? -w : w;
        xm  = (x < 0) ? -x : x;
        hi  = wm * (xm >> 16);
        lo  = (wm * (xm & 64'hFFFF) + 64'h8000) >> 16;
        m   = hi + lo;
        if (m > MAG_CAP)
            m = MAG_CAP;
        p = neg ? -longint'(m) : longint'(m);
        return clamp48(p + addend, ov);
    endfunction

    // Store the coefficient; on the last one, queue every derivative at the point.
    task automatic predict_derivatives(input coef_item_t it);
        longint       work [CAPACITY];
        longint       xv;
        bit           ov;
        int           n;
        result_item_t r;
        if (pred_count < CAPACITY) begin
            pred_coefs[pred_count] = longint'(it.coef);
            pred_count++;
        end else begin
            pred_dropped = 1'b1;
        end
        if (!it.last_coef)
            return;
        xv = longint'(it.x_point);
        ov = pred_dropped;
        n  = pred_count - 1;
        for (int i = 0; i <= n; i++)
            work[i] = pred_coefs[n];
        for (int i = n - 1; i >= 0; i--) begin
            work[0] = horner_mac(work[0], xv, pred_coefs[i], ov);
            for (int j = 1; j <= i; j++)
                work[j] = horner_mac(work[j], xv, work[j-1], ov);
        end
        // Scale the k-th Horner value by k factorial.
        for (int i = 2; i <= n; i++)
            for (int j = 2; j <= i; j++)
                work[i] = clamp48(work[i] * longint'(j), ov);
        for (int k = 0; k <= n; k++) begin
            r.deriv_value   = work[k][47:0];
            r.deriv_order   = 6'(k);
            r.last_result   = (k == n);
            r.overflow_flag = ov;
            deriv_expected_q.push_back(r);
        end
        pred_count   = 0;
        pred_dropped = 1'b0;
    endtask

    // Offer one coefficient transaction, with random idle cycles ahead of it.
    task automatic send_coef(input logic signed [31:0] c, input logic signed [31:0] x,
                             input logic last);
        coef_item_t it;
        it.coef      = c;
        it.x_point   = x;
        it.last_coef = last;
        while ($urandom_range(99) < send_idle_pct) begin
            coef_valid <= 1'b0;
            @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef_item  <= it;
        do
            @(posedge clk);
        while (!coef_ready);
        predict_derivatives(it);
        items_sent++;
        if (last)
            evals_sent++;
    endtask

    // Coefficients: mostly modest values, some full range, extremes and integers.
    function automatic logic signed [31:0] rand_coef();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = int'($urandom_range(0, 2097151)) - 1048576;
            5, 6:          v = int'($urandom);
            7:             v = $urandom_range(1) ? S32_MAX : S32_MIN;
            8:             v = (int'($urandom_range(0, 64)) - 32) <<< 16;
            default:       v = int'($urandom_range(0, 8)) - 4;
        endcase
        return v;
    endfunction

    // Evaluation points: mostly within +/-2.0, some fractions, full range and extremes.
    function automatic logic signed [31:0] rand_point();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = int'($urandom_range(0, 262144)) - 131072;
            5, 6:          v = int'($urandom_range(0, 65536)) - 32768;
            7, 8:          v = int'($urandom);
            default:
            begin
                case ($urandom_range(3))
                    0:       v = S32_MAX;
                    1:       v = S32_MIN;
                    2:       v = 0;
                    default: v = -Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    // Send a polynomial of n_coefs coefficients; only the last carries the real point.
    task automatic send_poly(input int n_coefs, input logic signed [31:0] x);
        for (int i = 0; i < n_coefs; i++) begin
            if (i == n_coefs - 1)
                send_coef(rand_coef(), x, 1'b1);
            else
                send_coef(rand_coef(), int'($urandom), 1'b0);
        end
    endtask

    // Constant polynomials at the extremes of coefficient and point.
    task automatic test_constant_poly();
        send_coef(S32_MAX, S32_MIN, 1'b1);
        send_coef(S32_MIN, S32_MAX, 1'b1);
        send_coef(32'sd0, 32'sd0, 1'b1);
    endtask

    // A full store of integer coefficients evaluated at 2.0.
    task automatic test_full_store();
        for (int i = 0; i < CAPACITY; i++)
            send_coef((i + 1) <<< 16, 2 * Q_ONE, i == CAPACITY - 1);
    endtask

    // Ten coefficients: the two beyond capacity, the last among them, are dropped.
    task automatic test_store_overflow();
        for (int i = 0; i < CAPACITY + 2; i++)
            send_coef(Q_ONE - (i <<< 14), -(Q_ONE + Q_HALF), i == CAPACITY + 1);
    endtask

    // Largest coefficients at the largest point give the largest Horner product.
    task automatic test_saturation();
        send_coef(S32_MAX, S32_MIN, 1'b0);
        send_coef(S32_MAX, S32_MAX, 1'b1);
    endtask

    // Products that land exactly on half an LSB round away from zero.
    task automatic test_rounding_ties();
        send_coef(32'sd0, 32'sd0, 1'b0);
        send_coef(32'sd1, Q_HALF, 1'b1);
        send_coef(32'sd0, 32'sd0, 1'b0);
        send_coef(32'sd3, -Q_HALF, 1'b1);
    endtask

    // Random polynomials, mostly well formed, some overfilling the store.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int target;
        int pick;
        target         = items_sent + n_items;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < target) begin
            pick = $urandom_range(9);
            send_poly((pick < 8) ? pick + 1 : $urandom_range(9, 11), rand_point());
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_output_stall();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = STALL_HOLD;
        for (int p = 0; p < 3; p++)
            send_poly(5, rand_point());
    endtask

    // Result sink: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk) begin : result_sink
        if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end else begin
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk) begin : result_check
        result_item_t want;
        if (rst_n && result_valid && result_ready) begin
            if (deriv_expected_q.size() == 0) begin
                fail_count++;
                $error("result transaction with none expected: value %0d order %0d",
                       result_item.deriv_value, result_item.deriv_order);
            end else begin
                want = deriv_expected_q.pop_front();
                results_checked++;
                if (result_item.deriv_value !== want.deriv_value) begin
                    fail_count++;
                    $error("deriv_value: expected %0d, got %0d",
                           want.deriv_value, result_item.deriv_value);
                end
                if (result_item.deriv_order !== want.deriv_order) begin
                    fail_count++;
                    $error("deriv_order: expected %0d, got %0d",
                           want.deriv_order, result_item.deriv_order);
                end
                if (result_item.last_result !== want.last_result) begin
                    fail_count++;
                    $error("last_result: expected %0b, got %0b",
                           want.last_result, result_item.last_result);
                end
                if (result_item.overflow_flag !== want.overflow_flag) begin
                    fail_count++;
                    $error("overflow_flag: expected %0b, got %0b",
                           want.overflow_flag, result_item.overflow_flag);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((coef_valid && coef_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d cycles without a transaction", QUIET_LIMIT);
        $display("FAIL poly_eval_all_derivatives");
        $finish;
    end

    // Reset, the test sequence, drain and verdict.
    initial begin : main_sequence
        clk              = 1'b0;
        rst_n            = 1'b0;
        coef_valid       = 1'b0;
        coef_item        = '0;
        pred_count       = 0;
        pred_dropped     = 1'b0;
        fail_count       = 0;
        items_sent       = 0;
        evals_sent       = 0;
        results_checked  = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_constant_poly();
        test_full_store();
        test_store_overflow();
        test_saturation();
        test_rounding_ties();
        test_random_traffic(60, 0, 0);
        test_random_traffic(60, 72, 0);
        test_random_traffic(60, 0, 72);
        test_random_traffic(60, 24, 24);
        test_output_stall();
        coef_valid <= 1'b0;

        while (deriv_expected_q.size() != 0)
            @(posedge clk);
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d coefficient transactions in %0d evaluations, %0d results checked,",
                 items_sent, evals_sent, results_checked);
        $display("including store overflow, saturation, rounding ties and a long output stall.");
        if (fail_count == 0)
            $display("PASS poly_eval_all_derivatives");
        else
            $display("FAIL poly_eval_all_derivatives");
        $finish;
    end

endmodule
